// ===== design/qbd_pkg.sv =====
// ============================================================================
// qbd_pkg - shared types, constants and conversions
// Format codes, queue transaction type, back-end states and the small
// number conversions used by the block dequantizer.
// ============================================================================
`default_nettype none

package qbd_pkg;

  localparam int STORE_BYTES_DEFAULT = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  typedef enum logic [3:0] {
    FMT_F32  = 4'd0,
    FMT_F16  = 4'd1,
    FMT_Q4_0 = 4'd2,
    FMT_Q4_1 = 4'd3,
    FMT_Q5_0 = 4'd4,
    FMT_Q5_1 = 4'd5,
    FMT_Q8_0 = 4'd6,
    FMT_Q8_1 = 4'd7,
    FMT_Q4_K = 4'd8,
    FMT_Q8_K = 4'd9
  } fmt_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [9:0] addr;
    logic [7:0] data;
    logic [7:0] elem;
  } cmd_t;

  typedef enum logic {
    FOP_MUL = 1'b0,
    FOP_ADD = 1'b1
  } fpu_op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_FETCH,
    BS_OP,
    BS_WAIT,
    BS_DONE
  } back_state_t;

  // Half to single, exact; subnormal halves are normalised.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       s;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] msb;
    logic [3:0] shn;
    logic [9:0] mn;
    logic [31:0] r;
    s   = h[15];
    ex  = h[14:10];
    man = h[9:0];
    msb = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) msb = 4'(i);
    end
    shn = 4'd10 - msb;
    mn  = man << shn;
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {s, 31'd0};
      else r = {s, 8'd113 - {4'd0, shn}, mn, 13'd0};
    end else if (ex == 5'h1F) begin
      if (man == 10'd0) r = {s, 8'hFF, 23'd0};
      else r = F32_QNAN;
    end else begin
      r = {s, {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

  // Small two's complement integer (9 bits) to single, exact.
  function automatic logic [31:0] int_to_f32(input logic [8:0] q);
    logic        s;
    logic [8:0]  neg;
    logic [7:0]  mag;
    logic [2:0]  p;
    logic [22:0] ext;
    logic [22:0] mant;
    s    = q[8];
    neg  = 9'd0 - q;
    mag  = s ? neg[7:0] : q[7:0];
    p    = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) p = 3'(i);
    end
    ext  = {15'd0, mag};
    mant = ext << (5'd23 - {2'd0, p});
    if (mag == 8'd0) return 32'd0;
    return {s, 8'd127 + {5'd0, p}, mant};
  endfunction

endpackage

`default_nettype wire

// ===== design/qbd_fpu.sv =====
// ============================================================================
// qbd_fpu - single precision multiply / add unit
// Three registered stages: operate, leading-one search, shift-round-pack.
// Round to nearest even, subnormals in and out, NaN out is canonical.
// ============================================================================
`default_nettype none

module qbd_fpu (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire qbd_pkg::fpu_op_t op,
  input  wire logic [31:0]     a,
  input  wire logic [31:0]     b,
  output logic                 done,
  output logic [31:0]          result
);

  // stage 1 -----------------------------------------------------------------
  logic [7:0]  a_e, b_e, a_ep, b_ep;
  logic [23:0] a_m, b_m;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [47:0] prod;
  logic        a_big;
  logic [7:0]  e_l, e_s, e_diff;
  logic [23:0] m_l, m_s;
  logic        s_l, s_s, eff_sub;
  logic [49:0] x_l, x_sf, x_sa, sum;
  logic        c_sign, c_nan, c_inf;
  logic [49:0] c_x;
  logic signed [10:0] c_e;

  logic        s1_valid, s1_sign, s1_nan, s1_inf;
  logic [49:0] s1_x;
  logic signed [10:0] s1_e;

  always_comb begin
    a_e    = a[30:23];
    b_e    = b[30:23];
    a_ep   = (a_e == 8'd0) ? 8'd1 : a_e;
    b_ep   = (b_e == 8'd0) ? 8'd1 : b_e;
    a_m    = {a_e != 8'd0, a[22:0]};
    b_m    = {b_e != 8'd0, b[22:0]};
    a_nan  = (a_e == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b_e == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a_e == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b_e == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;
    prod   = a_m * b_m;

    a_big  = {a_ep, a_m} >= {b_ep, b_m};
    e_l    = a_big ? a_ep : b_ep;
    e_s    = a_big ? b_ep : a_ep;
    m_l    = a_big ? a_m : b_m;
    m_s    = a_big ? b_m : a_m;
    s_l    = a_big ? a[31] : b[31];
    s_s    = a_big ? b[31] : a[31];
    e_diff = e_l - e_s;
    eff_sub = s_l != s_s;
    x_l    = {3'd0, m_l, 23'd0};
    x_sf   = {3'd0, m_s, 23'd0};
    if (e_diff >= 8'd50) begin
      x_sa = {49'd0, m_s != 24'd0};
    end else begin
      x_sa = (x_sf >> e_diff) | {49'd0, |(x_sf & ~({50{1'b1}} << e_diff))};
    end
    sum    = eff_sub ? (x_l - x_sa) : (x_l + x_sa);

    if (op == qbd_pkg::FOP_MUL) begin
      c_sign = a[31] ^ b[31];
      c_nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      c_inf  = a_inf | b_inf;
      c_x    = {2'd0, prod};
      c_e    = $signed({3'd0, a_ep}) + $signed({3'd0, b_ep}) - 11'sd126;
    end else begin
      c_nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      c_inf  = a_inf | b_inf;
      c_x    = sum;
      c_e    = $signed({3'd0, e_l}) + 11'sd1;
      if (c_inf) c_sign = a_inf ? a[31] : b[31];
      else if (sum == 50'd0 && eff_sub) c_sign = 1'b0;
      else c_sign = s_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_sign <= c_sign;
    s1_nan  <= c_nan;
    s1_inf  <= c_inf;
    s1_x    <= c_x;
    s1_e    <= c_e;
  end

  // stage 2: leading one and shift amount ------------------------------------
  logic [5:0]  lead;
  logic signed [10:0] eb, sh;
  logic [10:0] sh_mag;
  logic        normal;

  logic        s2_valid, s2_sign, s2_nan, s2_inf, s2_zero, s2_left;
  logic [49:0] s2_x;
  logic [5:0]  s2_amt;
  logic [9:0]  s2_ebase;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (s1_x[i]) lead = 6'(i);
    end
    eb     = s1_e + $signed({5'd0, lead}) - 11'sd47;
    normal = eb > 11'sd0;
    sh     = normal ? (11'sd49 - $signed({5'd0, lead})) : (s1_e + 11'sd1);
    sh_mag = sh[10] ? 11'(-sh) : 11'(sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sign  <= s1_sign;
    s2_nan   <= s1_nan;
    s2_inf   <= s1_inf;
    s2_zero  <= s1_x == 50'd0;
    s2_x     <= s1_x;
    s2_left  <= !sh[10];
    s2_amt   <= (sh_mag > 11'd63) ? 6'd63 : sh_mag[5:0];
    s2_ebase <= normal ? 10'(eb - 11'sd1) : 10'd0;
  end

  // stage 3: shift, round, pack ---------------------------------------------
  logic [49:0] xs;
  logic [23:0] m24;
  logic        rnd;
  logic [24:0] m25;
  logic [32:0] total;
  logic [31:0] packed_r;

  always_comb begin
    if (s2_left) begin
      xs = s2_x << s2_amt;
    end else begin
      xs = (s2_x >> s2_amt) | {49'd0, |(s2_x & ~({50{1'b1}} << s2_amt))};
    end
    m24   = xs[49:26];
    rnd   = xs[25] & ((|xs[24:0]) | m24[0]);
    m25   = {1'b0, m24} + {24'd0, rnd};
    total = {s2_ebase, 23'd0} + {8'd0, m25};
    if (s2_nan) packed_r = qbd_pkg::F32_QNAN;
    else if (s2_inf || total >= {10'd255, 23'd0}) packed_r = {s2_sign, 8'hFF, 23'd0};
    else if (s2_zero) packed_r = {s2_sign, 31'd0};
    else packed_r = {s2_sign, total[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    result <= packed_r;
  end

endmodule

`default_nettype wire

// ===== design/qbd_front.sv =====
// ============================================================================
// qbd_front - input side and transaction queue
// Accepts transactions, tags them as store write or element read, wraps
// the element index to the block size and queues them for the back end.
// ============================================================================
`default_nettype none

module qbd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        command,
  input  wire logic [9:0]  byte_offset,
  input  wire logic [7:0]  byte_value,
  input  wire logic [7:0]  element_index,
  input  wire logic [3:0]  fmt,
  output logic             head_valid,
  output qbd_pkg::cmd_t    head,
  input  wire logic        head_pop
);

  localparam int PW = (qbd_pkg::QUEUE_DEPTH > 1) ? $clog2(qbd_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(qbd_pkg::QUEUE_DEPTH + 1);

  qbd_pkg::cmd_t entry [qbd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  qbd_pkg::cmd_t incoming;
  logic          do_push, do_pop;

  always_comb begin
    incoming.kind = command ? qbd_pkg::CMD_READ : qbd_pkg::CMD_WRITE;
    incoming.addr = byte_offset;
    incoming.data = byte_value;
    case (fmt)
      qbd_pkg::FMT_Q4_0, qbd_pkg::FMT_Q4_1, qbd_pkg::FMT_Q5_0,
      qbd_pkg::FMT_Q5_1, qbd_pkg::FMT_Q8_0, qbd_pkg::FMT_Q8_1:
        incoming.elem = {3'd0, element_index[4:0]};
      default:
        incoming.elem = element_index;
    endcase
  end

  assign full       = count == CW'(qbd_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entry[rptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(qbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(qbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) entry[wptr] <= incoming;
  end

endmodule

`default_nettype wire

// ===== design/qbd_back.sv =====
// ============================================================================
// qbd_back - block store and element decode sequencer
// Executes queued transactions: byte writes into the store, element reads
// as a byte fetch burst, then for quantized formats a short float program.
// ============================================================================
`default_nettype none

module qbd_back #(
  parameter int STORE_BYTES = qbd_pkg::STORE_BYTES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [3:0]    fmt,
  input  wire logic          head_valid,
  input  wire qbd_pkg::cmd_t head,
  output logic               head_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [31:0]        value_bits
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int EW = ((AW > 10) ? AW : 10) + 1;

  function automatic logic [9:0] fetch_addr(input logic [3:0] f, input logic [7:0] e,
                                            input logic [2:0] st);
    logic [9:0] r;
    r = {7'd0, st};
    case (f)
      qbd_pkg::FMT_F32:  r = {e, st[1:0]};
      qbd_pkg::FMT_F16:  r = {1'b0, e, st[0]};
      qbd_pkg::FMT_Q4_0: if (st >= 3'd2) r = 10'd2 + {6'd0, e[3:0]};
      qbd_pkg::FMT_Q4_1: if (st >= 3'd4) r = 10'd4 + {6'd0, e[3:0]};
      qbd_pkg::FMT_Q5_0: begin
        if (st == 3'd2) r = 10'd2 + {8'd0, e[4:3]};
        else if (st >= 3'd3) r = 10'd6 + {6'd0, e[3:0]};
      end
      qbd_pkg::FMT_Q5_1: begin
        if (st == 3'd4) r = 10'd4 + {8'd0, e[4:3]};
        else if (st >= 3'd5) r = 10'd8 + {6'd0, e[3:0]};
      end
      qbd_pkg::FMT_Q8_0: if (st >= 3'd2) r = 10'd2 + {5'd0, e[4:0]};
      qbd_pkg::FMT_Q8_1: if (st >= 3'd2) r = 10'd4 + {5'd0, e[4:0]};
      qbd_pkg::FMT_Q4_K: begin
        case (st)
          3'd4:    r = 10'd8 + {7'd0, e[7:5]};
          3'd5:    r = {7'd0, e[7:5]};
          3'd6:    r = 10'd4 + {7'd0, e[7:5]};
          3'd7:    r = 10'd16 + {3'd0, e[7:6], e[4:0]};
          default: r = {7'd0, st};
        endcase
      end
      qbd_pkg::FMT_Q8_K: if (st >= 3'd4) r = 10'd4 + {2'd0, e};
      default: r = {7'd0, st};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] fetch_count(input logic [3:0] f);
    case (f)
      qbd_pkg::FMT_F32:  return 4'd4;
      qbd_pkg::FMT_F16:  return 4'd2;
      qbd_pkg::FMT_Q4_0: return 4'd3;
      qbd_pkg::FMT_Q4_1: return 4'd5;
      qbd_pkg::FMT_Q5_0: return 4'd4;
      qbd_pkg::FMT_Q5_1: return 4'd6;
      qbd_pkg::FMT_Q8_0: return 4'd3;
      qbd_pkg::FMT_Q8_1: return 4'd3;
      qbd_pkg::FMT_Q4_K: return 4'd8;
      qbd_pkg::FMT_Q8_K: return 4'd5;
      default:           return 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] last_op(input logic [3:0] f);
    case (f)
      qbd_pkg::FMT_Q4_1, qbd_pkg::FMT_Q5_1: return 2'd1;
      qbd_pkg::FMT_Q4_K:                    return 2'd3;
      default:                              return 2'd0;
    endcase
  endfunction

  function automatic logic in_store(input logic [9:0] addr);
    logic [EW-1:0] ext;
    ext = EW'(addr);
    return ext < EW'(STORE_BYTES);
  endfunction

  // store ---------------------------------------------------------------
  logic [7:0]    mem [STORE_BYTES];
  logic          mem_we;
  logic [EW-1:0] wr_ext, rd_ext;
  logic [9:0]    rd_addr;
  logic [7:0]    rdata;
  logic          rd_oob;

  assign wr_ext = EW'(head.addr);
  assign rd_ext = EW'(rd_addr);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_ext[AW-1:0]] <= head.data;
    rdata  <= mem[rd_ext[AW-1:0]];
    rd_oob <= !in_store(rd_addr);
  end

  // sequencer -------------------------------------------------------------
  qbd_pkg::back_state_t state, state_next;
  logic [7:0]  elem;
  logic [3:0]  step;
  logic [3:0]  n_fetch;
  logic        pend;
  logic [2:0]  pend_slot;
  logic [7:0]  slot [8];
  logic [1:0]  op_idx;
  logic [31:0] r [3];
  logic [31:0] res;
  logic        out_valid;
  logic [31:0] out_data;
  logic        direct;
  logic [31:0] direct_val;

  logic             fpu_start, fpu_done;
  qbd_pkg::fpu_op_t fpu_op;
  logic [31:0]      fpu_a, fpu_b, fpu_result;

  assign n_fetch = fetch_count(fmt);
  assign rd_addr = fetch_addr(fmt, elem, step[2:0]);

  // operand decode from fetched bytes
  logic [31:0] d_h, m_h, d_w, q_f, sc_f, mn_f;
  logic [7:0]  qs;
  logic [3:0]  nib;
  logic [8:0]  q9;
  logic [5:0]  sc, mn;

  always_comb begin
    d_h = qbd_pkg::half_to_f32({slot[1], slot[0]});
    m_h = qbd_pkg::half_to_f32({slot[3], slot[2]});
    d_w = {slot[3], slot[2], slot[1], slot[0]};
    case (fmt)
      qbd_pkg::FMT_Q4_0: qs = slot[2];
      qbd_pkg::FMT_Q4_1: qs = slot[4];
      qbd_pkg::FMT_Q5_0: qs = slot[3];
      qbd_pkg::FMT_Q5_1: qs = slot[5];
      default:           qs = slot[7];
    endcase
    nib = elem[4] ? qs[7:4] : qs[3:0];
    if (elem[7:5] < 3'd4) begin
      sc = slot[6][5:0];
      mn = slot[4][5:0];
    end else begin
      sc = {slot[5][7:6], slot[4][3:0]};
      mn = {slot[6][7:6], slot[4][7:4]};
    end
    case (fmt)
      qbd_pkg::FMT_Q4_0: q9 = {5'd0, nib} - 9'd8;
      qbd_pkg::FMT_Q4_1: q9 = {5'd0, nib};
      qbd_pkg::FMT_Q5_0: q9 = {4'd0, slot[2][elem[2:0]], nib} - 9'd16;
      qbd_pkg::FMT_Q5_1: q9 = {4'd0, slot[4][elem[2:0]], nib};
      qbd_pkg::FMT_Q4_K: q9 = {5'd0, elem[5] ? slot[7][7:4] : slot[7][3:0]};
      qbd_pkg::FMT_Q8_K: q9 = {slot[4][7], slot[4]};
      default:           q9 = {slot[2][7], slot[2]};
    endcase
    q_f  = qbd_pkg::int_to_f32(q9);
    sc_f = qbd_pkg::int_to_f32({3'd0, sc});
    mn_f = qbd_pkg::int_to_f32({3'd0, mn});

    fpu_op = qbd_pkg::FOP_MUL;
    fpu_a  = d_h;
    fpu_b  = q_f;
    case (fmt)
      qbd_pkg::FMT_Q4_1, qbd_pkg::FMT_Q5_1: begin
        if (op_idx == 2'd1) begin
          fpu_op = qbd_pkg::FOP_ADD;
          fpu_a  = r[0];
          fpu_b  = m_h;
        end
      end
      qbd_pkg::FMT_Q8_K: fpu_a = d_w;
      qbd_pkg::FMT_Q4_K: begin
        case (op_idx)
          2'd0: begin
            fpu_a = sc_f;
            fpu_b = d_h;
          end
          2'd1: begin
            fpu_a = r[0];
            fpu_b = q_f;
          end
          2'd2: begin
            fpu_a = mn_f;
            fpu_b = m_h;
          end
          default: begin
            fpu_op = qbd_pkg::FOP_ADD;
            fpu_a  = r[1];
            fpu_b  = {~r[2][31], r[2][30:0]};
          end
        endcase
      end
      default: ;
    endcase

    direct = 1'b1;
    case (fmt)
      qbd_pkg::FMT_F32: direct_val = d_w;
      qbd_pkg::FMT_F16: direct_val = d_h;
      qbd_pkg::FMT_Q4_0, qbd_pkg::FMT_Q4_1, qbd_pkg::FMT_Q5_0, qbd_pkg::FMT_Q5_1,
      qbd_pkg::FMT_Q8_0, qbd_pkg::FMT_Q8_1, qbd_pkg::FMT_Q4_K, qbd_pkg::FMT_Q8_K: begin
        direct     = 1'b0;
        direct_val = res;
      end
      default: direct_val = 32'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    mem_we     = 1'b0;
    fpu_start  = 1'b0;
    case (state)
      qbd_pkg::BS_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          if (head.kind == qbd_pkg::CMD_WRITE) mem_we = in_store(head.addr);
          else state_next = qbd_pkg::BS_FETCH;
        end
      end
      qbd_pkg::BS_FETCH: begin
        if (step == n_fetch) state_next = direct ? qbd_pkg::BS_DONE : qbd_pkg::BS_OP;
      end
      qbd_pkg::BS_OP: begin
        fpu_start  = 1'b1;
        state_next = qbd_pkg::BS_WAIT;
      end
      qbd_pkg::BS_WAIT: begin
        if (fpu_done) begin
          state_next = (op_idx == last_op(fmt)) ? qbd_pkg::BS_DONE : qbd_pkg::BS_OP;
        end
      end
      qbd_pkg::BS_DONE: begin
        if (!out_valid) state_next = qbd_pkg::BS_IDLE;
      end
      default: state_next = qbd_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qbd_pkg::BS_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == qbd_pkg::BS_FETCH) && (step != n_fetch);
      if (state == qbd_pkg::BS_DONE && !out_valid) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
    end
    pend_slot <= step[2:0];
    if (pend) slot[pend_slot] <= rd_oob ? 8'd0 : rdata;
    if (state == qbd_pkg::BS_IDLE && head_valid) begin
      elem   <= head.elem;
      step   <= 4'd0;
      op_idx <= 2'd0;
    end
    if (state == qbd_pkg::BS_FETCH && step != n_fetch) step <= step + 4'd1;
    if (state == qbd_pkg::BS_WAIT && fpu_done) begin
      if (op_idx != 2'd3) r[op_idx] <= fpu_result;
      res    <= fpu_result;
      op_idx <= op_idx + 2'd1;
    end
    if (state == qbd_pkg::BS_DONE && !out_valid) out_data <= direct_val;
  end

  assign empty      = !out_valid;
  assign value_bits = out_data;

  qbd_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_result)
  );

endmodule

`default_nettype wire

// ===== design/quantized_block_dequantizer.sv =====
// ============================================================================
// quantized_block_dequantizer - quantized block store and element decoder
// Holds one quantized block in a byte store and returns single precision
// values of its elements for the selected block format.
// ============================================================================
//
// Transactions enter through a two-entry queue (push/full) and results leave
// through a one-entry output register (empty/pop), so the input side keeps
// accepting while a result waits to be taken. A store write is carried out
// as the sequencer takes it from the head of the queue. A read is executed
// one at a time: the sequencer fetches the bytes it needs from the store
// through its single registered read port, one byte a cycle (two to eight
// bytes depending on the format); for the quantized formats it then runs one
// to four operations, one after another, on a shared three-stage float unit,
// and finally loads the output register. F32 and F16 values skip the float
// unit; an unused format code fetches no bytes and returns zero. Arithmetic
// is single precision with round to nearest even and full subnormal
// handling; every NaN from a half or from the float unit is returned as
// 0x7FC00000, while F32 elements are returned as stored. Bytes of the store
// read before ever being written give undefined values. The user must write
// the format register through format_we/format_select only while no read is
// outstanding; the block itself does not enforce this.
//
`default_nettype none

module quantized_block_dequantizer #(
  parameter int STORE_BYTES = qbd_pkg::STORE_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        format_we,
  input  wire logic [3:0]  format_select,
  input  wire logic        push,
  output logic             full,
  input  wire logic        command,
  input  wire logic [9:0]  byte_offset,
  input  wire logic [7:0]  byte_value,
  input  wire logic [7:0]  element_index,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      value_bits
);

  // format register, reset to F32
  logic [3:0] fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= qbd_pkg::FMT_F32;
    end else if (format_we) begin
      fmt <= format_select;
    end
  end

  // queue between front and back
  logic          head_valid;
  logic          head_pop;
  qbd_pkg::cmd_t head;

  qbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .byte_offset   (byte_offset),
    .byte_value    (byte_value),
    .element_index (element_index),
    .fmt           (fmt),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop)
  );

  qbd_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .fmt        (fmt),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .value_bits (value_bits)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top - block dequantizer testbench
// Drives byte writes and element reads through the push/full queue, predicts
// each element value from a private copy of the block store and format, and
// compares every popped value in order. Directed table first, then random
// phases over all formats, including the lowest and highest unused codes.
// ============================================================================
`default_nettype none

module tb_top;

  // unused format codes, lowest and highest
  localparam logic [3:0] FMT_SPARE_LO = 4'd10;
  localparam logic [3:0] FMT_SPARE_HI = 4'd15;
  localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
  localparam int DRAIN_CYCLES = 40;   // slowest read (Q4_K) plus margin
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int HOLD_AT = 300;       // transaction count that triggers it
  localparam int PHASE_ITEMS = 120;

  logic        clk;
  logic        rst;
  logic        format_we;
  logic [3:0]  format_select;
  logic        push;
  logic        full;
  logic        command;
  logic [9:0]  byte_offset;
  logic [7:0]  byte_value;
  logic [7:0]  element_index;
  logic        empty;
  logic        pop;
  logic [31:0] value_bits;

  quantized_block_dequantizer dut (
    .clk(clk), .rst(rst),
    .format_we(format_we), .format_select(format_select),
    .push(push), .full(full),
    .command(command), .byte_offset(byte_offset),
    .byte_value(byte_value), .element_index(element_index),
    .empty(empty), .pop(pop), .value_bits(value_bits)
  );

  // predictor state: block bytes, which ones hold data, current format
  logic [7:0]  blk_mem [1024];
  bit          blk_written [1024];
  logic [3:0]  fmt_cur;
  logic [31:0] value_q [$];   // expected element values, oldest first

  int errors;
  int items;
  int send_idle;
  int recv_idle;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous overall time limit for the roughly 1700 transactions of the run
  initial begin
    #(20 * 600000);
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Single precision helpers. Each float op is done in double (exact enough:
  // 53 >= 2*24+2 bits) and then rounded once to single, nearest even.
  // ---------------------------------------------------------------------------
  function automatic real sp_to_real(logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    real r;
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hFF)
      return $bitstoreal({b[31], 11'h7FF, (m != 0) ? 52'h8_0000_0000_0000 : 52'd0});
    if (e == 8'd0) begin
      if (m == 23'd0) return $bitstoreal({b[31], 63'd0});
      r = real'(m) * $bitstoreal(64'h36A0_0000_0000_0000);  // times 2^-149
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(e) + 896), m, 29'd0});
  endfunction

  function automatic logic [31:0] real_to_sp(real r);
    logic [63:0] b;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int ex;
    int sh;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF)
      return (b[51:0] != 0) ? qbd_pkg::F32_QNAN : (F32_POS_INF | {b[63], 31'd0});
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    ex = int'(b[62:52]) - 1023;
    if (ex > 127) return F32_POS_INF | {b[63], 31'd0};
    sig = {11'd0, 1'b1, b[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 54) return {b[63], 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (ex >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        ex++;
      end
      if (ex > 127) return F32_POS_INF | {b[63], 31'd0};
      return {b[63], 8'(ex + 127), kept[22:0]};
    end
    // subnormal; a carry into bit 23 lands on the smallest normal by itself
    return {b[63], kept[30:0]};
  endfunction

  function automatic real sp_round(real x);
    return sp_to_real(real_to_sp(x));
  endfunction

  // half to single, exact; NaN becomes the canonical quiet NaN
  function automatic logic [31:0] half_bits(logic [15:0] h);
    logic [10:0] mm;
    int ex;
    if (h[14:10] == 5'h1F)
      return (h[9:0] != 0) ? qbd_pkg::F32_QNAN : (F32_POS_INF | {h[15], 31'd0});
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) return {h[15], 31'd0};
      mm = {1'b0, h[9:0]};
      ex = 113;
      while (!mm[10]) begin
        mm = mm << 1;
        ex--;
      end
      return {h[15], 8'(ex), mm[9:0], 13'd0};
    end
    return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
  endfunction

  function automatic real half_at(int a);
    return sp_to_real(half_bits({blk_mem[a + 1], blk_mem[a]}));
  endfunction

  function automatic real sbyte_at(int a);
    return real'($signed(blk_mem[a]));
  endfunction

  function automatic int nibble_at(int base, int e);
    return (e < 16) ? int'(blk_mem[base + (e & 15)][3:0])
                    : int'(blk_mem[base + (e & 15)][7:4]);
  endfunction

  function automatic int qh_bit(int base, int e);
    return int'(blk_mem[base + (e >> 3)][e & 7]);
  endfunction

  // expected value bits of element idx under format fmt
  function automatic logic [31:0] dequant_value(logic [3:0] fmt, logic [7:0] idx);
    int e;
    int sub;
    int sc;
    int mn;
    int q;
    logic [7:0] hi;
    real d;
    real m;
    real t;
    real u;
    real v;
    e = (fmt == qbd_pkg::FMT_F32 || fmt == qbd_pkg::FMT_F16 ||
         fmt == qbd_pkg::FMT_Q4_K || fmt == qbd_pkg::FMT_Q8_K)
        ? int'(idx) : int'(idx) & 31;
    case (fmt)
      qbd_pkg::FMT_F32:
        return {blk_mem[4*e + 3], blk_mem[4*e + 2], blk_mem[4*e + 1], blk_mem[4*e]};
      qbd_pkg::FMT_F16:
        return half_bits({blk_mem[2*e + 1], blk_mem[2*e]});
      qbd_pkg::FMT_Q4_0:
        return real_to_sp(half_at(0) * real'(nibble_at(2, e) - 8));
      qbd_pkg::FMT_Q4_1: begin
        t = sp_round(half_at(0) * real'(nibble_at(4, e)));
        return real_to_sp(t + half_at(2));
      end
      qbd_pkg::FMT_Q5_0: begin
        q = (nibble_at(6, e) | (qh_bit(2, e) << 4)) - 16;
        return real_to_sp(half_at(0) * real'(q));
      end
      qbd_pkg::FMT_Q5_1: begin
        q = nibble_at(8, e) | (qh_bit(4, e) << 4);
        t = sp_round(half_at(0) * real'(q));
        return real_to_sp(t + half_at(2));
      end
      qbd_pkg::FMT_Q8_0: return real_to_sp(half_at(0) * sbyte_at(2 + e));
      qbd_pkg::FMT_Q8_1: return real_to_sp(half_at(0) * sbyte_at(4 + e));
      qbd_pkg::FMT_Q4_K: begin
        d = half_at(0);
        m = half_at(2);
        sub = e >> 5;
        if (sub < 4) begin
          sc = int'(blk_mem[4 + sub][5:0]);
          mn = int'(blk_mem[8 + sub][5:0]);
        end else begin
          hi = blk_mem[8 + sub];
          sc = int'(hi[3:0]) | (int'(blk_mem[sub][7:6]) << 4);
          mn = int'(hi[7:4]) | (int'(blk_mem[4 + sub][7:6]) << 4);
        end
        q = (sub & 1) ? int'(blk_mem[16 + (sub >> 1) * 32 + (e & 31)][7:4])
                      : int'(blk_mem[16 + (sub >> 1) * 32 + (e & 31)][3:0]);
        t = sp_round(real'(sc) * d);
        u = sp_round(t * real'(q));
        v = sp_round(real'(mn) * m);
        return real_to_sp(u - v);
      end
      qbd_pkg::FMT_Q8_K: begin
        d = sp_to_real({blk_mem[3], blk_mem[2], blk_mem[1], blk_mem[0]});
        return real_to_sp(d * sbyte_at(4 + e));
      end
      default: return 32'd0;
    endcase
  endfunction

  // byte addresses a read of idx touches, so none is read before written
  task automatic bytes_used(logic [3:0] fmt, logic [7:0] idx, ref int addrs[$]);
    int e;
    int sub;
    e = int'(idx);
    addrs = {};
    case (fmt)
      qbd_pkg::FMT_F32:  addrs = {4*e, 4*e + 1, 4*e + 2, 4*e + 3};
      qbd_pkg::FMT_F16:  addrs = {2*e, 2*e + 1};
      qbd_pkg::FMT_Q4_0: addrs = {0, 1, 2 + (e & 15)};
      qbd_pkg::FMT_Q4_1: addrs = {0, 1, 2, 3, 4 + (e & 15)};
      qbd_pkg::FMT_Q5_0: addrs = {0, 1, 2 + ((e & 31) >> 3), 6 + (e & 15)};
      qbd_pkg::FMT_Q5_1: addrs = {0, 1, 2, 3, 4 + ((e & 31) >> 3), 8 + (e & 15)};
      qbd_pkg::FMT_Q8_0: addrs = {0, 1, 2 + (e & 31)};
      qbd_pkg::FMT_Q8_1: addrs = {0, 1, 4 + (e & 31)};
      qbd_pkg::FMT_Q4_K: begin
        sub = e >> 5;
        addrs = {0, 1, 2, 3, 4 + sub, 8 + sub, sub, 16 + (sub >> 1) * 32 + (e & 31)};
      end
      qbd_pkg::FMT_Q8_K: addrs = {0, 1, 2, 3, 4 + e};
      default: addrs = {};
    endcase
  endtask

  // one transaction into the queue; the prediction is taken when accepted
  task automatic send(qbd_pkg::cmd_kind_t c, logic [9:0] a, logic [7:0] v,
                      logic [7:0] i, bit typed, logic [31:0] want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    command       <= c;
    byte_offset   <= a;
    byte_value    <= v;
    element_index <= i;
    @(posedge clk);
    while (full) @(posedge clk);
    if (c == qbd_pkg::CMD_WRITE) begin
      blk_mem[a]     = v;
      blk_written[a] = 1'b1;
    end else begin
      value_q.push_back(typed ? want : dequant_value(fmt_cur, i));
    end
    items++;
    if (items == HOLD_AT) hold_req = 1'b1;
    if (items < 600) begin
      send_idle = 24;
      recv_idle = 51;
    end else if (items < 1200) begin
      send_idle = 51;
      recv_idle = 24;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  // wait until the block is idle, then change the format register
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(logic [3:0] f);
    drain();
    @(negedge clk);
    format_we     <= 1'b1;
    format_select <= f;
    @(negedge clk);
    format_we <= 1'b0;
    fmt_cur = f;
  endtask

  // random read of an element; missing bytes are written first
  task automatic read_element(logic [7:0] idx);
    int addrs[$];
    bytes_used(fmt_cur, idx, addrs);
    foreach (addrs[k])
      if (!blk_written[addrs[k]])
        send(qbd_pkg::CMD_WRITE, 10'(addrs[k]), 8'($urandom_range(255)), 8'd0,
             1'b0, 32'd0);
    send(qbd_pkg::CMD_READ, 10'($urandom_range(1023)), 8'($urandom_range(255)), idx,
         1'b0, 32'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random pops, with one long hold-off to fill the block up
  // ---------------------------------------------------------------------------
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // result check on every popped transaction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (value_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb_top: unexpected value %h", value_bits);
      end else begin
        if (value_bits !== value_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("tb_top: value mismatch, expected %h got %h", value_q[0], value_bits);
        end
        void'(value_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [3:0]          fmt;
    qbd_pkg::cmd_kind_t  cmd;
    logic [9:0]          addr;
    logic [7:0]          val;
    logic [7:0]          idx;
    bit                  typed;
    logic [31:0]         want;
  } stim_row_t;

  stim_row_t   stim_tbl [$];
  logic [3:0]  phase_fmts [$];

  task automatic wr_row(logic [3:0] f, logic [9:0] a, logic [7:0] v);
    stim_tbl.push_back('{f, qbd_pkg::CMD_WRITE, a, v, 8'd0, 1'b0, 32'd0});
  endtask

  task automatic rd_row(logic [3:0] f, logic [7:0] i, bit typed, logic [31:0] want);
    stim_tbl.push_back('{f, qbd_pkg::CMD_READ, 10'd0, 8'd0, i, typed, want});
  endtask

  initial begin
    int n;
    rst           = 1'b1;
    format_we     = 1'b0;
    format_select = qbd_pkg::FMT_F32;
    push          = 1'b0;
    command       = qbd_pkg::CMD_WRITE;
    byte_offset   = 10'd0;
    byte_value    = 8'd0;
    element_index = 8'd0;
    fmt_cur       = qbd_pkg::FMT_F32;
    errors        = 0;
    items         = 0;
    send_idle     = 24;
    recv_idle     = 51;
    hold_req      = 1'b0;
    foreach (blk_written[k]) begin
      blk_written[k] = 1'b0;
      blk_mem[k]     = 8'd0;
    end

    // F32: 1.0 at element 0, all-ones word at the top of the store
    wr_row(qbd_pkg::FMT_F32, 10'd0, 8'h00);
    wr_row(qbd_pkg::FMT_F32, 10'd1, 8'h00);
    wr_row(qbd_pkg::FMT_F32, 10'd2, 8'h80);
    wr_row(qbd_pkg::FMT_F32, 10'd3, 8'h3F);
    rd_row(qbd_pkg::FMT_F32, 8'd0, 1'b1, 32'h3F80_0000);
    for (int a = 1020; a < 1024; a++) wr_row(qbd_pkg::FMT_F32, 10'(a), 8'hFF);
    rd_row(qbd_pkg::FMT_F32, 8'd255, 1'b1, 32'hFFFF_FFFF);
    // F16: half NaN, smallest subnormal, negative infinity
    wr_row(qbd_pkg::FMT_F16, 10'd0, 8'h00);
    wr_row(qbd_pkg::FMT_F16, 10'd1, 8'h7E);
    rd_row(qbd_pkg::FMT_F16, 8'd0, 1'b1, qbd_pkg::F32_QNAN);
    wr_row(qbd_pkg::FMT_F16, 10'd0, 8'h01);
    wr_row(qbd_pkg::FMT_F16, 10'd1, 8'h00);
    rd_row(qbd_pkg::FMT_F16, 8'd0, 1'b1, 32'h3380_0000);
    wr_row(qbd_pkg::FMT_F16, 10'd0, 8'h00);
    wr_row(qbd_pkg::FMT_F16, 10'd1, 8'hFC);
    rd_row(qbd_pkg::FMT_F16, 8'd0, 1'b1, 32'hFF80_0000);
    // Q4_0 with d = 1.0: low nibble 15 gives 7, high nibble 0 gives -8
    wr_row(qbd_pkg::FMT_Q4_0, 10'd1, 8'h3C);
    wr_row(qbd_pkg::FMT_Q4_0, 10'd2, 8'h0F);
    rd_row(qbd_pkg::FMT_Q4_0, 8'd0, 1'b1, 32'h40E0_0000);
    rd_row(qbd_pkg::FMT_Q4_0, 8'd16, 1'b0, 32'd0);
    rd_row(qbd_pkg::FMT_Q4_0, 8'd240, 1'b0, 32'd0);  // wraps onto element 16

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_tbl[k]) begin
      if (stim_tbl[k].fmt != fmt_cur) set_format(stim_tbl[k].fmt);
      send(stim_tbl[k].cmd, stim_tbl[k].addr, stim_tbl[k].val, stim_tbl[k].idx,
           stim_tbl[k].typed, stim_tbl[k].want);
    end

    // random phases: every format and unused codes at both ends
    phase_fmts = {qbd_pkg::FMT_Q4_0, qbd_pkg::FMT_Q4_1, qbd_pkg::FMT_Q5_0,
                  qbd_pkg::FMT_Q5_1, qbd_pkg::FMT_Q8_0, qbd_pkg::FMT_Q8_1,
                  qbd_pkg::FMT_Q4_K, qbd_pkg::FMT_Q8_K, FMT_SPARE_HI,
                  qbd_pkg::FMT_F16, qbd_pkg::FMT_F32, FMT_SPARE_LO,
                  qbd_pkg::FMT_Q4_K, qbd_pkg::FMT_Q5_1};
    foreach (phase_fmts[p]) begin
      set_format(phase_fmts[p]);
      n = items;
      while (items - n < PHASE_ITEMS) begin
        if ($urandom_range(99) < 30) begin
          // rewrite a byte, mostly in the scale and quant region
          send(qbd_pkg::CMD_WRITE,
               ($urandom_range(1) != 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(47)),
               8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 32'd0);
        end else begin
          read_element(8'($urandom_range(255)));
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/qbd_pkg.sv
design/qbd_fpu.sv
design/qbd_front.sv
design/qbd_back.sv
design/quantized_block_dequantizer.sv
verif/tb_top.sv
